// ----- src/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PRLM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PRLM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/prlm_pkg.sv -----
// shared types and constants of the page residency manager
// used by the tables, the fifo and the top level, no dependencies
`default_nettype none

package prlm_pkg;

	localparam int DEF_MAX_PAGES = 256;
	localparam int DEF_MAX_SLOTS = 64;

	localparam logic [1:0] KIND_FRAME   = 2'd0;
	localparam logic [1:0] KIND_REQUEST = 2'd1;
	localparam logic [1:0] KIND_UPLOAD  = 2'd2;
	localparam logic [1:0] KIND_LOOKUP  = 2'd3;

	localparam logic [2:0] ST_PLACED    = 3'd0;
	localparam logic [2:0] ST_DRAINED   = 3'd1;
	localparam logic [2:0] ST_LIMIT     = 3'd2;
	localparam logic [2:0] ST_NO_VICTIM = 3'd3;
	localparam logic [2:0] ST_LOOKUP    = 3'd4;

	localparam logic [7:0] CFG_PAGES_IN_USE = 8'd0;
	localparam logic [7:0] CFG_SLOTS_IN_USE = 8'd1;
	localparam logic [7:0] CFG_UPLOADS      = 8'd2;
	localparam logic [7:0] CFG_EVICT_AGE    = 8'd3;

	localparam logic [8:0] RST_PAGES_IN_USE = 9'd256;
	localparam logic [6:0] RST_SLOTS_IN_USE = 7'd64;
	localparam logic [5:0] RST_UPLOADS      = 6'd4;
	localparam logic [3:0] RST_EVICT_AGE    = 4'd2;

	localparam logic [5:0] UPLOAD_CAP = 6'd32;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] frame_number;
		logic [7:0]  page;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] page_out;
		logic [5:0] slot;
		logic       is_resident;
		logic       evicted_valid;
		logic [7:0] evicted_page;
		logic [6:0] resident_total;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

// ----- src/prlm_page_tbl.sv -----
// per-page stores: slot word, last-request frame, queued flag
// registered reads at one shared address, one write port per store
`default_nettype none

module prlm_page_tbl #(
	parameter int MAX_PAGES = prlm_pkg::DEF_MAX_PAGES,
	parameter int SW = 6
) (
	input  wire logic                         clk,
	input  wire logic [$clog2(MAX_PAGES)-1:0] rd_addr,
	output logic      [SW:0]                  rd_slot,
	output logic      [31:0]                  rd_lrf,
	output logic                              rd_queued,
	input  wire logic                         slot_we,
	input  wire logic [$clog2(MAX_PAGES)-1:0] slot_waddr,
	input  wire logic [SW:0]                  slot_wdata,
	input  wire logic                         lrf_we,
	input  wire logic [$clog2(MAX_PAGES)-1:0] lrf_waddr,
	input  wire logic [31:0]                  lrf_wdata,
	input  wire logic                         q_we,
	input  wire logic [$clog2(MAX_PAGES)-1:0] q_waddr,
	input  wire logic                         q_wdata
);

	// slot word: top bit is resident
	logic [SW:0] slot_mem_q [MAX_PAGES];
	logic [31:0] lrf_mem_q [MAX_PAGES];
	logic        queued_mem_q [MAX_PAGES];

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem_q[slot_waddr] <= slot_wdata;
		end
		if (lrf_we) begin
			lrf_mem_q[lrf_waddr] <= lrf_wdata;
		end
		if (q_we) begin
			queued_mem_q[q_waddr] <= q_wdata;
		end
		rd_slot   <= slot_mem_q[rd_addr];
		rd_lrf    <= lrf_mem_q[rd_addr];
		rd_queued <= queued_mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ----- src/prlm_slot_tbl.sv -----
// per-slot occupancy store, registered read
// depends on prlm_pkg for the default depth
`default_nettype none

module prlm_slot_tbl #(
	parameter int MAX_SLOTS = prlm_pkg::DEF_MAX_SLOTS,
	parameter int SW = 6
) (
	input  wire logic          clk,
	input  wire logic [SW-1:0] rd_addr,
	output logic               rd_used,
	input  wire logic          we,
	input  wire logic [SW-1:0] waddr,
	input  wire logic          wdata
);

	logic used_mem_q [MAX_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			used_mem_q[waddr] <= wdata;
		end
		rd_used <= used_mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ----- src/prlm_fifo.sv -----
// circular upload queue of page numbers with head and count
// depends on prlm_pkg for the default depth
`default_nettype none

module prlm_fifo #(
	parameter int MAX_PAGES = prlm_pkg::DEF_MAX_PAGES
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire logic [$clog2(MAX_PAGES)-1:0]   push_page,
	input  wire logic                           pop,
	input  wire logic                           unpop,
	input  wire logic                           head_clr,
	output logic      [$clog2(MAX_PAGES)-1:0]   rd_page,
	output logic      [$clog2(MAX_PAGES+1)-1:0] count
);

	localparam int PW  = $clog2(MAX_PAGES);
	localparam int CNW = $clog2(MAX_PAGES+1);

	logic [PW-1:0]  mem_q [MAX_PAGES];
	logic [PW-1:0]  head_q;
	logic [CNW-1:0] count_q;
	logic [PW:0]    tail_sum;
	logic [PW-1:0]  tail;

	// head + count stays below twice the depth
	always_comb begin
		tail_sum = {1'b0, head_q} + (PW+1)'(count_q);
		if (tail_sum >= (PW+1)'(MAX_PAGES)) begin
			tail = PW'(tail_sum - (PW+1)'(MAX_PAGES));
		end else begin
			tail = PW'(tail_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail] <= push_page;
		end
		rd_page <= mem_q[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				count_q <= count_q + 1'b1;
			end else if (pop) begin
				count_q <= count_q - 1'b1;
				head_q  <= (head_q == PW'(MAX_PAGES-1)) ? '0 : head_q + 1'b1;
			end else if (unpop) begin
				count_q <= count_q + 1'b1;
				head_q  <= (head_q == '0) ? PW'(MAX_PAGES-1) : head_q - 1'b1;
			end else if (head_clr) begin
				head_q <= '0;
			end
		end
	end

	assign count = count_q;

endmodule

`default_nettype wire

// ----- src/prlm_victim.sv -----
// shared age compare and oldest-page tracker for the eviction scan
// one candidate page per cycle, ties keep the lower page
`default_nettype none

module prlm_victim #(
	parameter int PW = 8,
	parameter int SW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          cand_valid,
	input  wire logic [PW-1:0] cand_page,
	input  wire logic [SW:0]   cand_slot,
	input  wire logic [31:0]   cand_last,
	input  wire logic [31:0]   frame,
	input  wire logic [3:0]    age,
	output logic               found,
	output logic [PW-1:0]      victim,
	output logic [SW-1:0]      vslot
);

	logic          found_q;
	logic [31:0]   vframe_q;
	logic [PW-1:0] victim_q;
	logic [SW-1:0] vslot_q;
	logic [32:0]   aged;
	logic          take;

	// no wrap: compare in 33 bits
	always_comb begin
		aged = {1'b0, cand_last} + 33'(age);
		take = cand_valid && cand_slot[SW] && (aged <= {1'b0, frame})
			&& (!found_q || (cand_last < vframe_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !start) begin
			vframe_q <= cand_last;
			victim_q <= cand_page;
			vslot_q  <= cand_slot[SW-1:0];
		end
	end

	assign found  = found_q;
	assign victim = victim_q;
	assign vslot  = vslot_q;

endmodule

`default_nettype wire

// ----- src/page_residency_lru_manager_top.sv -----
// page residency manager with least-recently-requested eviction, top level
// sequencer, config registers and result register; uses prlm_pkg and all prlm_* modules
//
// item channel (item_valid/item_ready, item): frame begin, page request, upload
// pass or lookup. item_ready is high only while the sequencer is idle.
// result channel (result_valid/result_ready, result): a one-entry output register,
// so the next item can be taken while the last result still waits.
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready, write only
// while idle.
// a frame begin is taken in idle; a request reads and updates its page entry, a lookup
// reads it and emits. upload pass: each queued page is popped and checked (a queued page
// already resident is skipped), then a free slot scan over slots_in_use and, when the pool
// is full, a victim scan over pages_in_use through the shared age compare and the eviction,
// then the place and emit steps; the close emits a drained or limit result.
// reset: a clearing pass over max(MAX_PAGES, MAX_SLOTS) entries wipes the tables;
// items wait until it ends. a stalled receiver holds the sequencer in its emit
// step until the result register frees up.
`default_nettype none
`include "assert_macros.svh"

module page_residency_lru_manager_top #(
	parameter int MAX_PAGES = prlm_pkg::DEF_MAX_PAGES,
	parameter int MAX_SLOTS = prlm_pkg::DEF_MAX_SLOTS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire prlm_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output prlm_pkg::result_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        cfg_index,
	input  wire logic [31:0]       cfg_data
);

	localparam int PW    = $clog2(MAX_PAGES);
	localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int PCW   = ($clog2(MAX_PAGES+1) > 9) ? $clog2(MAX_PAGES+1) : 9;
	localparam int SCW   = ($clog2(MAX_SLOTS+1) > 7) ? $clog2(MAX_SLOTS+1) : 7;
	localparam int IW    = (PCW > SCW) ? PCW : SCW;
	localparam int CNW   = $clog2(MAX_PAGES+1);
	localparam int RCW   = $clog2(MAX_SLOTS+1);
	localparam int CLR_N = (MAX_PAGES > MAX_SLOTS) ? MAX_PAGES : MAX_SLOTS;
	localparam int CW    = $clog2(CLR_N+1);

	typedef enum logic [11:0] {
		S_CLR    = 12'b0000_0000_0001,
		S_IDLE   = 12'b0000_0000_0010,
		S_REQ    = 12'b0000_0000_0100,
		S_LOOK   = 12'b0000_0000_1000,
		S_UP_CHK = 12'b0000_0001_0000,
		S_UP_POP = 12'b0000_0010_0000,
		S_UP_RES = 12'b0000_0100_0000,
		S_FREE   = 12'b0000_1000_0000,
		S_VIC    = 12'b0001_0000_0000,
		S_EVICT  = 12'b0010_0000_0000,
		S_PLACE  = 12'b0100_0000_0000,
		S_EMIT   = 12'b1000_0000_0000
	} state_t;

	state_t            st_q;
	logic [8:0]        pages_q;
	logic [6:0]        slots_q;
	logic [5:0]        uploads_q;
	logic [3:0]        age_q;
	logic [31:0]       frame_q;
	logic [RCW-1:0]    res_cnt_q;
	logic [CW-1:0]     clr_q;
	logic [7:0]        item_pg_q;
	logic              look_ok_q;
	logic [PW-1:0]     pg_q;
	logic [5:0]        placed_q;
	logic [IW-1:0]     idx_q;
	logic              pend_s1;
	logic [IW-1:0]     idx_s1;
	logic [SW-1:0]     slot_q;
	logic              evv_q;
	logic [PW-1:0]     evp_q;
	prlm_pkg::result_t rs_q;
	prlm_pkg::result_t result_q;
	logic              result_valid_q;

	logic [PCW-1:0]    eff_np;
	logic [SCW-1:0]    eff_ns;
	logic [5:0]        limit;
	logic              issue_free;
	logic              issue_vic;

	logic [PW-1:0]     pt_rd_addr;
	logic [SW:0]       pt_rd_slot;
	logic [31:0]       pt_rd_lrf;
	logic              pt_rd_queued;
	logic              pt_slot_we;
	logic [PW-1:0]     pt_slot_waddr;
	logic [SW:0]       pt_slot_wdata;
	logic              pt_lrf_we;
	logic [PW-1:0]     pt_lrf_waddr;
	logic [31:0]       pt_lrf_wdata;
	logic              pt_q_we;
	logic [PW-1:0]     pt_q_waddr;
	logic              pt_q_wdata;

	logic              sl_used;
	logic              sl_we;
	logic [SW-1:0]     sl_waddr;
	logic              sl_wdata;

	logic              ff_push;
	logic              ff_pop;
	logic              ff_unpop;
	logic              ff_head_clr;
	logic [PW-1:0]     ff_rd_page;
	logic [CNW-1:0]    ff_count;

	logic              vic_start;
	logic              vic_found;
	logic [PW-1:0]     vic_page;
	logic [SW-1:0]     vic_slot;

	logic              item_xfer;
	logic              emit_go;

	always_comb begin
		eff_np = (PCW'(pages_q) < PCW'(MAX_PAGES)) ? PCW'(pages_q) : PCW'(MAX_PAGES);
		eff_ns = (SCW'(slots_q) < SCW'(MAX_SLOTS)) ? SCW'(slots_q) : SCW'(MAX_SLOTS);
		limit  = (uploads_q > prlm_pkg::UPLOAD_CAP) ? prlm_pkg::UPLOAD_CAP : uploads_q;
		issue_free = idx_q < IW'(eff_ns);
		issue_vic  = idx_q < IW'(eff_np);
		item_xfer  = item_valid && item_ready;
		emit_go    = !result_valid_q || result_ready;
	end

	assign item_ready = (st_q == S_IDLE);
	assign cfg_ready  = 1'b1;

	// table ports, muxed by sequencer step
	always_comb begin
		pt_rd_addr    = idx_q[PW-1:0];
		pt_slot_we    = 1'b0;
		pt_slot_waddr = pg_q;
		pt_slot_wdata = {1'b1, slot_q};
		pt_lrf_we     = 1'b0;
		pt_lrf_waddr  = pg_q;
		pt_lrf_wdata  = frame_q;
		pt_q_we       = 1'b0;
		pt_q_waddr    = pg_q;
		pt_q_wdata    = 1'b0;
		sl_we         = 1'b0;
		sl_waddr      = slot_q;
		sl_wdata      = 1'b1;
		ff_push       = 1'b0;
		ff_pop        = 1'b0;
		ff_unpop      = 1'b0;
		ff_head_clr   = 1'b0;
		vic_start     = 1'b0;
		case (st_q)
			S_CLR: begin
				pt_slot_waddr = clr_q[PW-1:0];
				pt_slot_wdata = '0;
				pt_lrf_waddr  = clr_q[PW-1:0];
				pt_lrf_wdata  = '0;
				pt_q_waddr    = clr_q[PW-1:0];
				pt_slot_we    = clr_q < CW'(MAX_PAGES);
				pt_lrf_we     = clr_q < CW'(MAX_PAGES);
				pt_q_we       = clr_q < CW'(MAX_PAGES);
				sl_waddr      = clr_q[SW-1:0];
				sl_wdata      = 1'b0;
				sl_we         = clr_q < CW'(MAX_SLOTS);
			end
			S_IDLE: begin
				pt_rd_addr = PW'(item.page);
			end
			S_REQ: begin
				if (!pt_rd_slot[SW]) begin
					pt_lrf_we = 1'b1;
					if (!pt_rd_queued && ff_count < CNW'(MAX_PAGES)) begin
						pt_q_we    = 1'b1;
						pt_q_wdata = 1'b1;
						ff_push    = 1'b1;
					end
				end
			end
			S_UP_CHK: begin
				ff_head_clr = (ff_count == '0);
			end
			S_UP_POP: begin
				pt_rd_addr = ff_rd_page;
				pt_q_waddr = ff_rd_page;
				pt_q_we    = 1'b1;
				ff_pop     = 1'b1;
			end
			S_FREE: begin
				vic_start = 1'b1;
			end
			S_VIC: begin
				if (!issue_vic && !pend_s1 && !vic_found) begin
					pt_q_we    = 1'b1;
					pt_q_wdata = 1'b1;
					ff_unpop   = 1'b1;
				end
			end
			S_EVICT: begin
				pt_slot_we    = 1'b1;
				pt_slot_waddr = vic_page;
				pt_slot_wdata = '0;
			end
			S_PLACE: begin
				pt_slot_we = 1'b1;
				pt_lrf_we  = 1'b1;
				sl_we      = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= S_CLR;
			clr_q          <= '0;
			pages_q        <= prlm_pkg::RST_PAGES_IN_USE;
			slots_q        <= prlm_pkg::RST_SLOTS_IN_USE;
			uploads_q      <= prlm_pkg::RST_UPLOADS;
			age_q          <= prlm_pkg::RST_EVICT_AGE;
			frame_q        <= '0;
			res_cnt_q      <= '0;
			pend_s1        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					prlm_pkg::CFG_PAGES_IN_USE: pages_q   <= cfg_data[8:0];
					prlm_pkg::CFG_SLOTS_IN_USE: slots_q   <= cfg_data[6:0];
					prlm_pkg::CFG_UPLOADS:      uploads_q <= cfg_data[5:0];
					prlm_pkg::CFG_EVICT_AGE:    age_q     <= cfg_data[3:0];
					default: begin
					end
				endcase
			end
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CLR_N-1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_xfer) begin
						case (item.kind)
							prlm_pkg::KIND_FRAME: begin
								frame_q <= item.frame_number;
							end
							prlm_pkg::KIND_REQUEST: begin
								if (PCW'(item.page) < eff_np) begin
									st_q <= S_REQ;
								end
							end
							prlm_pkg::KIND_UPLOAD: begin
								st_q <= S_UP_CHK;
							end
							default: begin
								st_q <= S_LOOK;
							end
						endcase
					end
				end
				S_REQ: begin
					st_q <= S_IDLE;
				end
				S_LOOK: begin
					st_q <= S_EMIT;
				end
				S_UP_CHK: begin
					if (ff_count == '0 || placed_q == limit) begin
						st_q <= S_EMIT;
					end else begin
						st_q <= S_UP_POP;
					end
				end
				S_UP_POP: begin
					st_q <= S_UP_RES;
				end
				S_UP_RES: begin
					pend_s1 <= 1'b0;
					st_q    <= pt_rd_slot[SW] ? S_UP_CHK : S_FREE;
				end
				S_FREE: begin
					pend_s1 <= issue_free;
					if (pend_s1 && !sl_used) begin
						pend_s1 <= 1'b0;
						st_q    <= S_PLACE;
					end else if (!issue_free && !pend_s1) begin
						st_q <= S_VIC;
					end
				end
				S_VIC: begin
					pend_s1 <= issue_vic;
					if (!issue_vic && !pend_s1) begin
						st_q <= vic_found ? S_EVICT : S_EMIT;
					end
				end
				S_EVICT: begin
					if (res_cnt_q != '0) begin
						res_cnt_q <= res_cnt_q - 1'b1;
					end
					st_q <= S_PLACE;
				end
				S_PLACE: begin
					res_cnt_q <= res_cnt_q + 1'b1;
					st_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						result_valid_q <= 1'b1;
						st_q <= rs_q.last ? S_IDLE : S_UP_CHK;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				item_pg_q <= item.page;
				pg_q      <= PW'(item.page);
				look_ok_q <= PCW'(item.page) < PCW'(MAX_PAGES);
				placed_q  <= '0;
			end
			S_LOOK: begin
				rs_q.status         <= prlm_pkg::ST_LOOKUP;
				rs_q.page_out       <= item_pg_q;
				rs_q.is_resident    <= look_ok_q && pt_rd_slot[SW];
				rs_q.slot           <= (look_ok_q && pt_rd_slot[SW]) ?
					6'(pt_rd_slot[SW-1:0]) : 6'd0;
				rs_q.evicted_valid  <= 1'b0;
				rs_q.evicted_page   <= '0;
				rs_q.resident_total <= 7'(res_cnt_q);
				rs_q.last           <= 1'b1;
			end
			S_UP_CHK: begin
				rs_q.status         <= (ff_count == '0) ? prlm_pkg::ST_DRAINED :
					prlm_pkg::ST_LIMIT;
				rs_q.page_out       <= '0;
				rs_q.slot           <= '0;
				rs_q.is_resident    <= 1'b0;
				rs_q.evicted_valid  <= 1'b0;
				rs_q.evicted_page   <= '0;
				rs_q.resident_total <= 7'(res_cnt_q);
				rs_q.last           <= 1'b1;
			end
			S_UP_POP: begin
				pg_q <= ff_rd_page;
			end
			S_UP_RES: begin
				idx_q <= '0;
			end
			S_FREE: begin
				if (issue_free) begin
					idx_q <= idx_q + 1'b1;
				end
				idx_s1 <= idx_q;
				if (pend_s1 && !sl_used) begin
					slot_q <= idx_s1[SW-1:0];
					evv_q  <= 1'b0;
					evp_q  <= '0;
				end else if (!issue_free && !pend_s1) begin
					idx_q <= '0;
				end
			end
			S_VIC: begin
				if (issue_vic) begin
					idx_q <= idx_q + 1'b1;
				end
				idx_s1 <= idx_q;
				rs_q.status         <= prlm_pkg::ST_NO_VICTIM;
				rs_q.page_out       <= 8'(pg_q);
				rs_q.slot           <= '0;
				rs_q.is_resident    <= 1'b0;
				rs_q.evicted_valid  <= 1'b0;
				rs_q.evicted_page   <= '0;
				rs_q.resident_total <= 7'(res_cnt_q);
				rs_q.last           <= 1'b1;
			end
			S_EVICT: begin
				slot_q <= vic_slot;
				evv_q  <= 1'b1;
				evp_q  <= vic_page;
			end
			S_PLACE: begin
				placed_q            <= placed_q + 1'b1;
				rs_q.status         <= prlm_pkg::ST_PLACED;
				rs_q.page_out       <= 8'(pg_q);
				rs_q.slot           <= 6'(slot_q);
				rs_q.is_resident    <= 1'b1;
				rs_q.evicted_valid  <= evv_q;
				rs_q.evicted_page   <= 8'(evp_q);
				// count as it stands once this page is placed
				rs_q.resident_total <= 7'(res_cnt_q + 1'b1);
				rs_q.last           <= 1'b0;
			end
			S_EMIT: begin
				if (emit_go) begin
					result_q <= rs_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	prlm_page_tbl #(
		.MAX_PAGES (MAX_PAGES),
		.SW        (SW)
	) u_page_tbl (
		.clk        (clk),
		.rd_addr    (pt_rd_addr),
		.rd_slot    (pt_rd_slot),
		.rd_lrf     (pt_rd_lrf),
		.rd_queued  (pt_rd_queued),
		.slot_we    (pt_slot_we),
		.slot_waddr (pt_slot_waddr),
		.slot_wdata (pt_slot_wdata),
		.lrf_we     (pt_lrf_we),
		.lrf_waddr  (pt_lrf_waddr),
		.lrf_wdata  (pt_lrf_wdata),
		.q_we       (pt_q_we),
		.q_waddr    (pt_q_waddr),
		.q_wdata    (pt_q_wdata)
	);

	prlm_slot_tbl #(
		.MAX_SLOTS (MAX_SLOTS),
		.SW        (SW)
	) u_slot_tbl (
		.clk     (clk),
		.rd_addr (idx_q[SW-1:0]),
		.rd_used (sl_used),
		.we      (sl_we),
		.waddr   (sl_waddr),
		.wdata   (sl_wdata)
	);

	prlm_fifo #(
		.MAX_PAGES (MAX_PAGES)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ff_push),
		.push_page (pg_q),
		.pop       (ff_pop),
		.unpop     (ff_unpop),
		.head_clr  (ff_head_clr),
		.rd_page   (ff_rd_page),
		.count     (ff_count)
	);

	prlm_victim #(
		.PW (PW),
		.SW (SW)
	) u_victim (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (vic_start),
		.cand_valid (pend_s1 && (st_q == S_VIC)),
		.cand_page  (idx_s1[PW-1:0]),
		.cand_slot  (pt_rd_slot),
		.cand_last  (pt_rd_lrf),
		.frame      (frame_q),
		.age        (age_q),
		.found      (vic_found),
		.victim     (vic_page),
		.vslot      (vic_slot)
	);

	`PRLM_ASSERT_NOW(a_res_bound, 1'b1, res_cnt_q <= RCW'(MAX_SLOTS), "resident count over pool")
	`PRLM_ASSERT_NOW(a_fifo_bound, 1'b1, ff_count <= CNW'(MAX_PAGES), "upload queue overflow")
	`PRLM_ASSERT_NEXT(a_place_cnt, st_q == S_PLACE, res_cnt_q != '0, "placed page not counted")
	`PRLM_ASSERT_NOW(a_evict_found, st_q == S_EVICT, vic_found, "eviction without victim")

endmodule

`default_nettype wire

// ----- verif/tb_page_residency_lru_manager_top.sv -----
// testbench for the page residency manager: directed and random items against
// an in-bench residency predictor, with random idling on both channels
// depends on prlm_pkg and page_residency_lru_manager_top
`timescale 1ns / 1ps

module tb_page_residency_lru_manager_top;

	localparam int NPAGES = 256;
	localparam int NSLOTS = 64;
	localparam int DRAIN_CYCLES = 24;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_LEN = 300;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	prlm_pkg::item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	prlm_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	page_residency_lru_manager_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// residency predictor state
	int slot_of_page[NPAGES];
	int page_of_slot[NSLOTS];
	logic [31:0] req_frame[NPAGES];
	bit queued[NPAGES];
	logic [7:0] pending_pages[NPAGES];
	int q_head;
	int q_count;
	logic [31:0] cur_frame;
	int resident_cnt;
	logic [8:0] reg_pages;
	logic [6:0] reg_slots;
	logic [5:0] reg_uploads;
	logic [3:0] reg_age;

	prlm_pkg::result_t expected_results[$];
	int error_count = 0;
	bit quiet = 1'b0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_cycles = 0;
	int ready_gap = 0;
	int idle_cycles = 0;
	logic [31:0] frame_ctr = '0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic prlm_pkg::result_t make_result(logic [2:0] st, int pg, int sl,
			bit res, bit evv, int evp, bit lst);
		prlm_pkg::result_t r;
		r.status = st;
		r.page_out = pg[7:0];
		r.slot = sl[5:0];
		r.is_resident = res;
		r.evicted_valid = evv;
		r.evicted_page = evp[7:0];
		r.resident_total = resident_cnt[6:0];
		r.last = lst;
		return r;
	endfunction

	function automatic void queue_expected(prlm_pkg::result_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void reset_residency();
		for (int i = 0; i < NPAGES; i++) begin
			slot_of_page[i] = -1;
			req_frame[i] = '0;
			queued[i] = 1'b0;
			pending_pages[i] = '0;
		end
		for (int i = 0; i < NSLOTS; i++) page_of_slot[i] = -1;
		q_head = 0;
		q_count = 0;
		cur_frame = '0;
		resident_cnt = 0;
		reg_pages = prlm_pkg::RST_PAGES_IN_USE;
		reg_slots = prlm_pkg::RST_SLOTS_IN_USE;
		reg_uploads = prlm_pkg::RST_UPLOADS;
		reg_age = prlm_pkg::RST_EVICT_AGE;
	endfunction

	function automatic int active_pages();
		return (reg_pages < NPAGES) ? int'(reg_pages) : NPAGES;
	endfunction

	// lowest free slot, else the oldest old-enough resident page's slot
	function automatic int grab_slot(output int victim);
		int ns;
		int best;
		logic [31:0] best_frame;
		ns = (reg_slots < NSLOTS) ? int'(reg_slots) : NSLOTS;
		victim = -1;
		best = -1;
		best_frame = '0;
		for (int s = 0; s < ns; s++)
			if (page_of_slot[s] < 0) return s;
		for (int p = 0; p < active_pages(); p++) begin
			if (slot_of_page[p] < 0) continue;
			if (longint'(req_frame[p]) + longint'(reg_age) > longint'(cur_frame)) continue;
			if (best < 0 || req_frame[p] < best_frame) begin
				best = p;
				best_frame = req_frame[p];
			end
		end
		if (best < 0) return -1;
		victim = best;
		best = slot_of_page[victim];
		slot_of_page[victim] = -1;
		page_of_slot[best] = -1;
		if (resident_cnt > 0) resident_cnt--;
		return best;
	endfunction

	function automatic void run_upload_pass();
		int limit;
		int placed;
		int pg;
		int sl;
		int victim;
		limit = (reg_uploads < prlm_pkg::UPLOAD_CAP) ? int'(reg_uploads) :
			int'(prlm_pkg::UPLOAD_CAP);
		placed = 0;
		while (q_count > 0 && placed < limit) begin
			pg = pending_pages[q_head];
			q_head = (q_head + 1) % NPAGES;
			q_count--;
			queued[pg] = 1'b0;
			if (slot_of_page[pg] >= 0) continue;
			sl = grab_slot(victim);
			if (sl < 0) begin
				q_head = (q_head + NPAGES - 1) % NPAGES;
				q_count++;
				queued[pg] = 1'b1;
				queue_expected(make_result(prlm_pkg::ST_NO_VICTIM, pg, 0, 1'b0, 1'b0, 0,
					1'b1));
				return;
			end
			slot_of_page[pg] = sl;
			page_of_slot[sl] = pg;
			req_frame[pg] = cur_frame;
			resident_cnt++;
			placed++;
			queue_expected(make_result(prlm_pkg::ST_PLACED, pg, sl, 1'b1, victim >= 0,
				(victim >= 0) ? victim : 0, 1'b0));
		end
		if (q_count == 0) begin
			q_head = 0;
			queue_expected(make_result(prlm_pkg::ST_DRAINED, 0, 0, 1'b0, 1'b0, 0, 1'b1));
		end else begin
			queue_expected(make_result(prlm_pkg::ST_LIMIT, 0, 0, 1'b0, 1'b0, 0, 1'b1));
		end
	endfunction

	function automatic void predict_item(prlm_pkg::item_t it);
		int pg;
		pg = it.page;
		case (it.kind)
			prlm_pkg::KIND_FRAME: begin
				cur_frame = it.frame_number;
			end
			prlm_pkg::KIND_REQUEST: begin
				if (pg < active_pages() && slot_of_page[pg] < 0) begin
					req_frame[pg] = cur_frame;
					if (!queued[pg] && q_count < NPAGES) begin
						queued[pg] = 1'b1;
						pending_pages[(q_head + q_count) % NPAGES] = pg[7:0];
						q_count++;
					end
				end
			end
			prlm_pkg::KIND_LOOKUP: begin
				if (slot_of_page[pg] >= 0)
					queue_expected(make_result(prlm_pkg::ST_LOOKUP, pg, slot_of_page[pg],
						1'b1, 1'b0, 0, 1'b1));
				else
					queue_expected(make_result(prlm_pkg::ST_LOOKUP, pg, 0, 1'b0, 1'b0, 0,
						1'b1));
			end
			default: begin
				run_upload_pass();
			end
		endcase
	endfunction

	task automatic send_item(logic [1:0] kind, logic [31:0] frame, logic [7:0] pg);
		prlm_pkg::item_t it;
		it.kind = kind;
		it.frame_number = frame;
		it.page = pg;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		predict_item(it);
	endtask

	// wait until every expected result has come and the block has gone quiet
	task automatic settle();
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_registers(logic [8:0] pages, logic [6:0] slots, logic [5:0] ups,
			logic [3:0] age);
		logic [31:0] vals[4];
		logic [7:0] idxs[4];
		int wds[4];
		settle();
		idxs = '{prlm_pkg::CFG_PAGES_IN_USE, prlm_pkg::CFG_SLOTS_IN_USE,
			prlm_pkg::CFG_UPLOADS, prlm_pkg::CFG_EVICT_AGE};
		vals = '{{23'd0, pages}, {25'd0, slots}, {26'd0, ups}, {28'd0, age}};
		wds = '{9, 7, 6, 4};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[i];
			// upper data bits are don't-care, toggle them too
			cfg_data <= vals[i] | ($urandom() & ~((32'd1 << wds[i]) - 32'd1));
			do @(posedge clk); while (!cfg_ready);
			case (idxs[i])
				prlm_pkg::CFG_PAGES_IN_USE: reg_pages = pages;
				prlm_pkg::CFG_SLOTS_IN_USE: reg_slots = slots;
				prlm_pkg::CFG_UPLOADS: reg_uploads = ups;
				default: reg_age = age;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// one frame of typical traffic: frame begin, requests, upload pass, lookups
	task automatic frame_sequence(int max_req);
		int span;
		span = (active_pages() + 4 < NPAGES) ? active_pages() + 4 : NPAGES;
		frame_ctr = frame_ctr + $urandom_range(0, 3);
		send_item(prlm_pkg::KIND_FRAME, frame_ctr, 8'($urandom()));
		repeat ($urandom_range(0, max_req))
			send_item(prlm_pkg::KIND_REQUEST, $urandom(), 8'($urandom_range(0, span - 1)));
		send_item(prlm_pkg::KIND_UPLOAD, $urandom(), 8'($urandom()));
		repeat ($urandom_range(0, 2))
			send_item(prlm_pkg::KIND_LOOKUP, $urandom(), 8'($urandom_range(0, span - 1)));
	endtask

	task automatic noise_item();
		send_item(2'($urandom()), $urandom(), 8'($urandom()));
	endtask

	task automatic test_defaults_directed();
		send_item(prlm_pkg::KIND_LOOKUP, 32'd0, 8'd0);
		send_item(prlm_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 8'd255);
		send_item(prlm_pkg::KIND_UPLOAD, 32'd0, 8'd0);
		send_item(prlm_pkg::KIND_REQUEST, 32'd0, 8'd255);
		send_item(prlm_pkg::KIND_REQUEST, 32'd0, 8'd0);
		send_item(prlm_pkg::KIND_REQUEST, 32'd0, 8'd255);
		for (int p = 1; p <= 4; p++) send_item(prlm_pkg::KIND_REQUEST, 32'd0, 8'(p * 50));
		send_item(prlm_pkg::KIND_UPLOAD, 32'd0, 8'd0);
		send_item(prlm_pkg::KIND_REQUEST, 32'd0, 8'd255);
		send_item(prlm_pkg::KIND_UPLOAD, 32'd0, 8'd0);
		send_item(prlm_pkg::KIND_LOOKUP, 32'd0, 8'd255);
		send_item(prlm_pkg::KIND_LOOKUP, 32'd0, 8'd200);
		send_item(prlm_pkg::KIND_FRAME, 32'hFFFF_FFFF, 8'hFF);
		send_item(prlm_pkg::KIND_REQUEST, 32'd0, 8'd77);
		send_item(prlm_pkg::KIND_UPLOAD, 32'd0, 8'd0);
		send_item(prlm_pkg::KIND_FRAME, 32'hAAAA_5555, 8'd0);
		send_item(prlm_pkg::KIND_FRAME, 32'h5555_AAAA, 8'd0);
		send_item(prlm_pkg::KIND_LOOKUP, 32'd0, 8'd77);
	endtask

	// extremes of every register, with eviction forced through a tiny pool
	task automatic test_register_extremes();
		write_registers(9'd1, 7'd1, 6'd0, 4'd0);
		send_item(prlm_pkg::KIND_REQUEST, 32'd0, 8'd0);
		send_item(prlm_pkg::KIND_REQUEST, 32'd0, 8'd1);
		send_item(prlm_pkg::KIND_UPLOAD, 32'd0, 8'd0);
		write_registers(9'd8, 7'd1, 6'd63, 4'd0);
		for (int i = 0; i < 4; i++) begin
			frame_ctr = frame_ctr + 1;
			send_item(prlm_pkg::KIND_FRAME, frame_ctr, 8'd0);
			send_item(prlm_pkg::KIND_REQUEST, 32'd0, 8'(i));
			send_item(prlm_pkg::KIND_REQUEST, 32'd0, 8'(i + 4));
			send_item(prlm_pkg::KIND_UPLOAD, 32'd0, 8'd0);
		end
		write_registers(9'd8, 7'd2, 6'd32, 4'd15);
		repeat (3) frame_sequence(8);
		write_registers(9'd0, 7'd0, 6'd5, 4'd1);
		repeat (2) frame_sequence(4);
		send_item(prlm_pkg::KIND_LOOKUP, 32'd0, 8'd3);
		write_registers(9'd511, 7'd127, 6'd33, 4'd0);
		repeat (3) frame_sequence(10);
		write_registers(9'd256, 7'd64, 6'd32, 4'd2);
		repeat (3) frame_sequence(12);
	endtask

	task automatic test_random_traffic(int phases);
		for (int ph = 0; ph < phases; ph++) begin
			if ($urandom_range(0, 3) == 0)
				write_registers(9'($urandom_range(130, 256)), 7'($urandom_range(1, 64)),
					6'($urandom_range(0, 40)), 4'($urandom_range(0, 15)));
			else
				write_registers(9'($urandom_range(2, 40)), 7'($urandom_range(1, 6)),
					6'($urandom_range(1, 8)), 4'($urandom_range(0, 3)));
			repeat (5) begin
				if ($urandom_range(0, 9) == 0) noise_item();
				else frame_sequence(6);
			end
		end
	endtask

	// receiver holds off long enough for the output register and sequencer to back up
	task automatic test_output_stall();
		hold_req = hold_req + 1;
		repeat (20) send_item(prlm_pkg::KIND_LOOKUP, $urandom(), 8'($urandom()));
		frame_sequence(6);
	endtask

	task automatic test_full_rate();
		quiet = 1'b1;
		repeat (6) frame_sequence(5);
	endtask

	// receiver side: random stall bursts, or a long counted hold-off
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			result_ready <= 1'b0;
			hold_cycles <= HOLD_LEN - 1;
		end else if (hold_cycles > 0) begin
			result_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (ready_gap > 0) begin
			result_ready <= 1'b0;
			ready_gap <= ready_gap - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			result_ready <= 1'b0;
			ready_gap <= $urandom_range(0, 4);
		end else begin
			result_ready <= 1'b1;
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		prlm_pkg::result_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer: %p", result);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.status !== exp_r.status) begin
					$error("status expected %0d actual %0d", exp_r.status, result.status);
					error_count++;
				end
				if (result.page_out !== exp_r.page_out) begin
					$error("page_out expected %0d actual %0d", exp_r.page_out, result.page_out);
					error_count++;
				end
				if (result.slot !== exp_r.slot) begin
					$error("slot expected %0d actual %0d", exp_r.slot, result.slot);
					error_count++;
				end
				if (result.is_resident !== exp_r.is_resident) begin
					$error("is_resident expected %0d actual %0d", exp_r.is_resident,
						result.is_resident);
					error_count++;
				end
				if (result.evicted_valid !== exp_r.evicted_valid) begin
					$error("evicted_valid expected %0d actual %0d", exp_r.evicted_valid,
						result.evicted_valid);
					error_count++;
				end
				if (result.evicted_page !== exp_r.evicted_page) begin
					$error("evicted_page expected %0d actual %0d", exp_r.evicted_page,
						result.evicted_page);
					error_count++;
				end
				if (result.resident_total !== exp_r.resident_total) begin
					$error("resident_total expected %0d actual %0d", exp_r.resident_total,
						result.resident_total);
					error_count++;
				end
				if (result.last !== exp_r.last) begin
					$error("last expected %0d actual %0d", exp_r.last, result.last);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		reset_residency();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_defaults_directed();
		test_register_extremes();
		test_random_traffic(6);
		test_output_stall();
		test_full_rate();
		settle();
		if (expected_results.size() == 0 && error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
